// ===== rtl/core/ieh_pkg.sv =====
// shared types, constants and codes of the ion exit energy histogram
package ieh_pkg;

    localparam int ENERGY_BINS_DEF = 256;
    localparam int ANGLE_BINS_DEF  = 256;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DIV_W           = 41;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] REG_THICKNESS = 3'd0;
    localparam logic [2:0] REG_ION_RANGE = 3'd1;
    localparam logic [2:0] REG_INIT_EN   = 3'd2;
    localparam logic [2:0] REG_LOSS_EXP  = 3'd3;
    localparam logic [2:0] REG_EBIN_W    = 3'd4;
    localparam logic [2:0] REG_ABIN_W    = 3'd5;

    localparam logic [23:0] THICKNESS_RST = 24'd3000;
    localparam logic [23:0] ION_RANGE_RST = 24'd10400;
    localparam logic [31:0] INIT_EN_RST   = 32'd68000;
    localparam logic [15:0] LOSS_EXP_RST  = 16'd5939;
    localparam logic [31:0] EBIN_W_RST    = 32'd500;
    localparam logic [15:0] ABIN_W_RST    = 16'd328;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] depth;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [15:0] z;
        logic [7:0]  rei;
        logic [7:0]  rai;
        logic        rd_ok;
    } item_t;

    typedef struct packed {
        logic [23:0] thickness;
        logic [23:0] ion_range;
        logic [31:0] initial_energy;
        logic [15:0] loss_exponent;
        logic [31:0] energy_bin_width;
        logic [15:0] angle_bin_width;
    } cfg_t;

    typedef struct packed {
        logic        escaped;
        logic [31:0] exit_energy;
        logic [7:0]  energy_bin;
        logic [7:0]  angle_bin;
        logic [31:0] bin_count;
        logic [31:0] escape_total;
        logic [31:0] sample_total;
    } res_t;

    typedef struct packed {
        logic idle;
        logic init_clear;
    } back_stat_t;

endpackage

// ===== rtl/core/ieh_front.sv =====
// front end: accepts commands, folds direction signs and checks read indexes
module ieh_front #(
    parameter int ENERGY_BINS = ieh_pkg::ENERGY_BINS_DEF,
    parameter int ANGLE_BINS  = ieh_pkg::ANGLE_BINS_DEF
) (
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic [15:0]        depth_draw,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic [15:0]        dir_z,
    input  logic [7:0]         read_energy_index,
    input  logic [7:0]         read_angle_index,
    input  logic               q_full,
    input  logic               busy,
    output logic               q_wr,
    output ieh_pkg::item_t     q_item
);

    logic [16:0] xs;
    logic [16:0] ys;

    assign full = q_full | busy;
    assign q_wr = push & ~full;

    // doubled components, magnitude only matters for the squares
    assign xs = {dir_x, 1'b0};
    assign ys = {dir_y, 1'b0};

    always_comb
    begin
        q_item.cmd   = command;
        q_item.depth = depth_draw;
        q_item.ax    = xs[16] ? (~xs + 17'd1) : xs;
        q_item.ay    = ys[16] ? (~ys + 17'd1) : ys;
        q_item.z     = dir_z;
        q_item.rei   = read_energy_index;
        q_item.rai   = read_angle_index;
        q_item.rd_ok = (32'(read_energy_index) < 32'(ENERGY_BINS))
                    && (32'(read_angle_index) < 32'(ANGLE_BINS));
    end

endmodule

// ===== rtl/core/ieh_fifo.sv =====
// short command queue between front end and sequencer
module ieh_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  ieh_pkg::item_t wdata,
    input  logic           rd,
    output ieh_pkg::item_t rdata,
    output logic           full,
    output logic           empty
);

    localparam int PW = (ieh_pkg::QUEUE_DEPTH > 1) ? $clog2(ieh_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(ieh_pkg::QUEUE_DEPTH + 1);

    ieh_pkg::item_t slot_reg [ieh_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign full  = (cnt_reg == NW'(ieh_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr & ~full;
    assign do_rd = rd & ~empty;
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(ieh_pkg::QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(ieh_pkg::QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ieh_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle
module ieh_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] v,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                v_reg    <= v;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            else if (busy_reg)
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/ieh_div.sv =====
// restoring divider, one quotient bit per cycle, 32 quotient bits
module ieh_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ieh_pkg::DIV_W-1:0] rem0,
    input  logic [31:0]              dvd,
    input  logic [ieh_pkg::DIV_W-1:0] den,
    output logic                     done,
    output logic [31:0]              quo
);

    localparam int W = ieh_pkg::DIV_W;

    logic         busy_reg;
    logic         done_reg;
    logic [4:0]   cnt_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] den_reg;
    logic [31:0]  dvd_reg;
    logic [31:0]  q_reg;
    logic [W:0]   sh;
    logic         ge;

    assign sh   = {rem_reg, dvd_reg[31]};
    assign ge   = (sh >= {1'b0, den_reg});
    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= rem0;
                den_reg  <= den;
                dvd_reg  <= dvd;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? W'(sh - {1'b0, den_reg}) : W'(sh);
                q_reg   <= {q_reg[30:0], ge};
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/ieh_back.sv =====
// back end sequencer: sample arithmetic, count store, counters and clearing
module ieh_back #(
    parameter int ENERGY_BINS = ieh_pkg::ENERGY_BINS_DEF,
    parameter int ANGLE_BINS  = ieh_pkg::ANGLE_BINS_DEF,
    parameter int COUNT_BITS  = ieh_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ieh_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  ieh_pkg::item_t      q_head,
    output logic                q_pop,
    output logic                res_valid,
    output ieh_pkg::res_t       res,
    input  logic                res_ready,
    output ieh_pkg::back_stat_t stat
);

    localparam int EB    = $clog2(ENERGY_BINS);
    localparam int AB    = $clog2(ANGLE_BINS);
    localparam int CELLS = ENERGY_BINS * ANGLE_BINS;
    localparam int CW    = $clog2(CELLS);
    localparam int CB    = COUNT_BITS;
    localparam int W     = ieh_pkg::DIV_W;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CLEAR = 5'd1;
    localparam logic [4:0] ST_RD    = 5'd2;
    localparam logic [4:0] ST_SQX   = 5'd3;
    localparam logic [4:0] ST_SQY   = 5'd4;
    localparam logic [4:0] ST_SQZ   = 5'd5;
    localparam logic [4:0] ST_SQS   = 5'd6;
    localparam logic [4:0] ST_NORM  = 5'd7;
    localparam logic [4:0] ST_COS   = 5'd8;
    localparam logic [4:0] ST_MD    = 5'd9;
    localparam logic [4:0] ST_MDEN  = 5'd10;
    localparam logic [4:0] ST_FRAC  = 5'd11;
    localparam logic [4:0] ST_PROOT = 5'd12;
    localparam logic [4:0] ST_PMUL  = 5'd13;
    localparam logic [4:0] ST_SBIT  = 5'd14;
    localparam logic [4:0] ST_SACC  = 5'd15;
    localparam logic [4:0] ST_SSQW  = 5'd16;
    localparam logic [4:0] ST_EWAIT = 5'd17;
    localparam logic [4:0] ST_EDIV  = 5'd18;
    localparam logic [4:0] ST_ABIN  = 5'd19;
    localparam logic [4:0] ST_ADIV  = 5'd20;
    localparam logic [4:0] ST_MRD   = 5'd21;
    localparam logic [4:0] ST_MINC  = 5'd22;
    localparam logic [4:0] ST_OUT   = 5'd23;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (&v) ? v : v + CB'(1);
    endfunction

    function automatic logic [31:0] rep32(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [EB-1:0] clamp_e(input logic [31:0] q);
        return (q > 32'(ENERGY_BINS - 1)) ? EB'(ENERGY_BINS - 1) : EB'(q);
    endfunction

    function automatic logic [AB-1:0] clamp_a(input logic [31:0] q);
        return (q > 32'(ANGLE_BINS - 1)) ? AB'(ANGLE_BINS - 1) : AB'(q);
    endfunction

    function automatic logic [CW-1:0] cell_addr(input logic [31:0] e, input logic [31:0] a);
        return CW'(e * 32'(ANGLE_BINS) + a);
    endfunction

    // count store
    logic [CB-1:0] mem [CELLS];
    logic [CB-1:0] rdata_reg;
    logic          mem_we;
    logic [CW-1:0] mem_addr;
    logic [CB-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // shared multiplier, registered product
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_top;
    logic [63:0] prod_reg;
    logic [31:0] mb_reg;
    logic        mtop_reg;
    logic [31:0] mq;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        mb_reg   <= mul_b;
        mtop_reg <= mul_top;
    end

    // q0.32 product where an operand of exactly one passes the other through
    assign mq = mtop_reg ? mb_reg : prod_reg[63:32];

    // arithmetic units
    logic          sq_start;
    logic [63:0]   sq_v;
    logic          sq_done;
    logic [31:0]   sq_root;
    logic          dv_start;
    logic [W-1:0]  dv_rem0;
    logic [31:0]   dv_dvd;
    logic [W-1:0]  dv_den;
    logic          dv_done;
    logic [31:0]   dv_quo;

    ieh_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (sq_v),
        .done  (sq_done),
        .root  (sq_root)
    );

    ieh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .rem0  (dv_rem0),
        .dvd   (dv_dvd),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    // sequencer state
    logic [4:0]      state_reg,  state_next;
    logic            init_reg,   init_next;
    logic [CW-1:0]   clr_reg,    clr_next;
    ieh_pkg::item_t  item_reg,   item_next;
    logic [CB-1:0]   esc_cnt_reg, esc_cnt_next;
    logic [CB-1:0]   smp_cnt_reg, smp_cnt_next;
    logic [33:0]     s2_reg,     s2_next;
    logic [16:0]     c_reg,      c_next;
    logic [W-1:0]    d_reg,      d_next;
    logic [31:0]     r_reg,      r_next;
    logic [31:0]     s_reg,      s_next;
    logic [32:0]     acc_reg,    acc_next;
    logic [3:0]      bix_reg,    bix_next;
    logic [EB-1:0]   ebin_reg,   ebin_next;
    logic [AB-1:0]   abin_reg,   abin_next;
    logic            o_esc_reg,  o_esc_next;
    logic [31:0]     o_en_reg,   o_en_next;
    logic [7:0]      o_eb_reg,   o_eb_next;
    logic [7:0]      o_ab_reg,   o_ab_next;
    logic [CB-1:0]   o_cnt_reg,  o_cnt_next;
    logic [W-1:0]    den_now;
    logic [CB-1:0]   cnt_inc;
    logic [CW-1:0]   bin_addr;

    assign den_now  = prod_reg[W-1:0];
    assign cnt_inc  = sat_inc(rdata_reg);
    assign bin_addr = cell_addr(32'(ebin_reg), 32'(abin_reg));

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        esc_cnt_next = esc_cnt_reg;
        smp_cnt_next = smp_cnt_reg;
        s2_next      = s2_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        acc_next     = acc_reg;
        bix_next     = bix_reg;
        ebin_next    = ebin_reg;
        abin_next    = abin_reg;
        o_esc_next   = o_esc_reg;
        o_en_next    = o_en_reg;
        o_eb_next    = o_eb_reg;
        o_ab_next    = o_ab_reg;
        o_cnt_next   = o_cnt_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = bin_addr;
        mem_wdata    = cnt_inc;
        mul_a        = '0;
        mul_b        = '0;
        mul_top      = 1'b0;
        sq_start     = 1'b0;
        sq_v         = {r_reg, 32'h0};
        dv_start     = 1'b0;
        dv_rem0      = '0;
        dv_dvd       = '0;
        dv_den       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                mem_addr = cell_addr(32'(q_head.rei), 32'(q_head.rai));
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_head;
                    o_esc_next = 1'b0;
                    o_en_next  = '0;
                    o_eb_next  = '0;
                    o_ab_next  = '0;
                    o_cnt_next = '0;
                    case (q_head.cmd)
                        ieh_pkg::CMD_SAMPLE:
                        begin
                            smp_cnt_next = sat_inc(smp_cnt_reg);
                            state_next   = (q_head.z == '0) ? ST_OUT : ST_SQX;
                        end
                        ieh_pkg::CMD_READ:
                        begin
                            o_eb_next  = q_head.rei;
                            o_ab_next  = q_head.rai;
                            state_next = q_head.rd_ok ? ST_RD : ST_OUT;
                        end
                        ieh_pkg::CMD_CLEAR:
                        begin
                            esc_cnt_next = '0;
                            smp_cnt_next = '0;
                            clr_next     = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(CELLS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_OUT;
                end
            end
            ST_RD:
            begin
                o_cnt_next = rdata_reg;
                state_next = ST_OUT;
            end
            ST_SQX:
            begin
                mul_a      = 32'(item_reg.ax);
                mul_b      = 32'(item_reg.ax);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                s2_next    = prod_reg[33:0];
                mul_a      = 32'(item_reg.ay);
                mul_b      = 32'(item_reg.ay);
                state_next = ST_SQZ;
            end
            ST_SQZ:
            begin
                s2_next    = s2_reg + prod_reg[33:0];
                mul_a      = 32'(item_reg.z);
                mul_b      = 32'(item_reg.z);
                state_next = ST_SQS;
            end
            ST_SQS:
            begin
                sq_start   = 1'b1;
                sq_v       = 64'(s2_reg + prod_reg[33:0]);
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (sq_done)
                begin
                    dv_start   = 1'b1;
                    dv_dvd     = {item_reg.z, 16'h0};
                    dv_den     = W'(sq_root);
                    state_next = ST_COS;
                end
            end
            ST_COS:
            begin
                if (dv_done)
                begin
                    c_next = dv_quo[16:0];
                    mul_a  = 32'(cfg.thickness);
                    mul_b  = 32'(17'h10000 - 17'(item_reg.depth));
                    state_next = (dv_quo[16:0] == '0) ? ST_OUT : ST_MD;
                end
            end
            ST_MD:
            begin
                d_next     = prod_reg[W-1:0];
                mul_a      = 32'(cfg.ion_range);
                mul_b      = 32'(c_reg);
                state_next = ST_MDEN;
            end
            ST_MDEN:
            begin
                // escape test is exact: depth path against range times cosine
                if (d_reg < den_now)
                begin
                    dv_start   = 1'b1;
                    dv_rem0    = den_now - d_reg;
                    dv_den     = den_now;
                    state_next = ST_FRAC;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FRAC:
            begin
                if (dv_done)
                begin
                    r_next     = dv_quo;
                    s_next     = dv_quo;
                    acc_next   = 33'h1_0000_0000;
                    bix_next   = 4'd11;
                    sq_start   = 1'b1;
                    sq_v       = {dv_quo, 32'h0};
                    state_next = ST_PROOT;
                end
            end
            ST_PROOT:
            begin
                if (sq_done)
                begin
                    r_next = sq_root;
                    if (cfg.loss_exponent[bix_reg])
                    begin
                        mul_a      = acc_reg[31:0];
                        mul_top    = acc_reg[32];
                        mul_b      = sq_root;
                        state_next = ST_PMUL;
                    end
                    else if (bix_reg == 4'd0)
                    begin
                        bix_next   = 4'd12;
                        state_next = ST_SBIT;
                    end
                    else
                    begin
                        bix_next = bix_reg - 4'd1;
                        sq_start = 1'b1;
                        sq_v     = {sq_root, 32'h0};
                    end
                end
            end
            ST_PMUL:
            begin
                acc_next = {1'b0, mq};
                if (bix_reg == 4'd0)
                begin
                    bix_next   = 4'd12;
                    state_next = ST_SBIT;
                end
                else
                begin
                    bix_next   = bix_reg - 4'd1;
                    sq_start   = 1'b1;
                    sq_v       = {r_reg, 32'h0};
                    state_next = ST_PROOT;
                end
            end
            ST_SBIT:
            begin
                // integer part of the exponent by square and multiply
                if (cfg.loss_exponent[bix_reg])
                begin
                    mul_a      = acc_reg[31:0];
                    mul_top    = acc_reg[32];
                    mul_b      = s_reg;
                    state_next = ST_SACC;
                end
                else
                begin
                    mul_a      = s_reg;
                    mul_b      = s_reg;
                    state_next = ST_SSQW;
                end
            end
            ST_SACC:
            begin
                acc_next   = {1'b0, mq};
                mul_a      = s_reg;
                mul_b      = s_reg;
                state_next = ST_SSQW;
            end
            ST_SSQW:
            begin
                s_next = mq;
                if (bix_reg == 4'd15)
                begin
                    mul_a      = acc_reg[31:0];
                    mul_top    = acc_reg[32];
                    mul_b      = cfg.initial_energy;
                    state_next = ST_EWAIT;
                end
                else
                begin
                    bix_next   = bix_reg + 4'd1;
                    state_next = ST_SBIT;
                end
            end
            ST_EWAIT:
            begin
                o_en_next  = mq;
                o_esc_next = 1'b1;
                if (cfg.energy_bin_width == '0)
                begin
                    ebin_next  = EB'(ENERGY_BINS - 1);
                    state_next = ST_ABIN;
                end
                else
                begin
                    dv_start   = 1'b1;
                    dv_dvd     = mq;
                    dv_den     = W'(cfg.energy_bin_width);
                    state_next = ST_EDIV;
                end
            end
            ST_EDIV:
            begin
                if (dv_done)
                begin
                    ebin_next  = clamp_e(dv_quo);
                    state_next = ST_ABIN;
                end
            end
            ST_ABIN:
            begin
                if (cfg.angle_bin_width == '0)
                begin
                    abin_next  = AB'(ANGLE_BINS - 1);
                    state_next = ST_MRD;
                end
                else
                begin
                    dv_start   = 1'b1;
                    dv_dvd     = 32'(c_reg);
                    dv_den     = W'(cfg.angle_bin_width);
                    state_next = ST_ADIV;
                end
            end
            ST_ADIV:
            begin
                if (dv_done)
                begin
                    abin_next  = clamp_a(dv_quo);
                    state_next = ST_MRD;
                end
            end
            ST_MRD:
            begin
                o_eb_next  = 8'(ebin_reg);
                o_ab_next  = 8'(abin_reg);
                state_next = ST_MINC;
            end
            ST_MINC:
            begin
                mem_we       = 1'b1;
                o_cnt_next   = cnt_inc;
                esc_cnt_next = sat_inc(esc_cnt_reg);
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            init_reg    <= 1'b1;
            clr_reg     <= '0;
            esc_cnt_reg <= '0;
            smp_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_reg     <= clr_next;
            esc_cnt_reg <= esc_cnt_next;
            smp_cnt_reg <= smp_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        s2_reg    <= s2_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        r_reg     <= r_next;
        s_reg     <= s_next;
        acc_reg   <= acc_next;
        bix_reg   <= bix_next;
        ebin_reg  <= ebin_next;
        abin_reg  <= abin_next;
        o_esc_reg <= o_esc_next;
        o_en_reg  <= o_en_next;
        o_eb_reg  <= o_eb_next;
        o_ab_reg  <= o_ab_next;
        o_cnt_reg <= o_cnt_next;
    end

    assign res_valid        = (state_reg == ST_OUT);
    assign res.escaped      = o_esc_reg;
    assign res.exit_energy  = o_en_reg;
    assign res.energy_bin   = o_eb_reg;
    assign res.angle_bin    = o_ab_reg;
    assign res.bin_count    = rep32(o_cnt_reg);
    assign res.escape_total = rep32(esc_cnt_reg);
    assign res.sample_total = rep32(smp_cnt_reg);

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.init_clear = init_reg;

endmodule

// ===== rtl/core/ion_exit_energy_histogram.sv =====
// top level of the ion exit energy histogram engine
// Commands enter through a queue style port (push/full) and each one gives
// exactly one result on the queue style result port (empty/pop); a two-entry
// command queue and a result register let both sides stall independently.
// One shared square-root unit runs once for the norm and twelve times for the
// fractional part of the loss exponent, one shared restoring divider runs for
// the cosine, the escape fraction and, unless a bin width is zero, the two bin
// indexes, and one shared 32x32 multiplier handles the squares, the path
// products, the power chain and the energy product. A clear sweeps every
// entry of the count store. After reset the count store is swept to zero, one
// entry a cycle, over all ENERGY_BINS*ANGLE_BINS entries (65536 at the default
// size); full stays high during that pass while configuration writes are still
// taken. Configuration writes complete in the cycle they are valid.
module ion_exit_energy_histogram #(
    parameter int ENERGY_BINS = ieh_pkg::ENERGY_BINS_DEF,
    parameter int ANGLE_BINS  = ieh_pkg::ANGLE_BINS_DEF,
    parameter int COUNT_BITS  = ieh_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // command side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic [15:0]        depth_draw,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic [15:0]        dir_z,
    input  logic [7:0]         read_energy_index,
    input  logic [7:0]         read_angle_index,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic               escaped,
    output logic [31:0]        exit_energy,
    output logic [7:0]         energy_bin,
    output logic [7:0]         angle_bin,
    output logic [31:0]        bin_count,
    output logic [31:0]        escape_total,
    output logic [31:0]        sample_total,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // configuration registers
    ieh_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thickness        <= ieh_pkg::THICKNESS_RST;
            cfg_reg.ion_range        <= ieh_pkg::ION_RANGE_RST;
            cfg_reg.initial_energy   <= ieh_pkg::INIT_EN_RST;
            cfg_reg.loss_exponent    <= ieh_pkg::LOSS_EXP_RST;
            cfg_reg.energy_bin_width <= ieh_pkg::EBIN_W_RST;
            cfg_reg.angle_bin_width  <= ieh_pkg::ABIN_W_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes beyond the register list are dropped
            case (cfg_index)
                ieh_pkg::REG_THICKNESS: cfg_reg.thickness        <= cfg_data[23:0];
                ieh_pkg::REG_ION_RANGE: cfg_reg.ion_range        <= cfg_data[23:0];
                ieh_pkg::REG_INIT_EN:   cfg_reg.initial_energy   <= cfg_data;
                ieh_pkg::REG_LOSS_EXP:  cfg_reg.loss_exponent    <= cfg_data[15:0];
                ieh_pkg::REG_EBIN_W:    cfg_reg.energy_bin_width <= cfg_data;
                ieh_pkg::REG_ABIN_W:    cfg_reg.angle_bin_width  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end and command queue
    ieh_pkg::item_t      wr_item;
    ieh_pkg::item_t      head_item;
    logic                q_wr;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    ieh_pkg::back_stat_t back_stat;

    ieh_front #(
        .ENERGY_BINS (ENERGY_BINS),
        .ANGLE_BINS  (ANGLE_BINS)
    ) u_front (
        .push              (push),
        .full              (full),
        .command           (command),
        .depth_draw        (depth_draw),
        .dir_x             (dir_x),
        .dir_y             (dir_y),
        .dir_z             (dir_z),
        .read_energy_index (read_energy_index),
        .read_angle_index  (read_angle_index),
        .q_full            (q_full),
        .busy              (back_stat.init_clear),
        .q_wr              (q_wr),
        .q_item            (wr_item)
    );

    ieh_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (wr_item),
        .rd    (q_pop),
        .rdata (head_item),
        .full  (q_full),
        .empty (q_empty)
    );

    // sequencer with count store and arithmetic units
    logic          back_valid;
    logic          back_ready;
    ieh_pkg::res_t back_res;

    ieh_back #(
        .ENERGY_BINS (ENERGY_BINS),
        .ANGLE_BINS  (ANGLE_BINS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (head_item),
        .q_pop     (q_pop),
        .res_valid (back_valid),
        .res       (back_res),
        .res_ready (back_ready),
        .stat      (back_stat)
    );

    // result register, refilled in the cycle the waiting transaction is taken
    logic          out_valid_reg;
    ieh_pkg::res_t out_reg;

    assign back_ready = ~out_valid_reg | pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (back_ready)
        begin
            out_valid_reg <= back_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_ready && back_valid)
        begin
            out_reg <= back_res;
        end
    end

    assign empty        = ~out_valid_reg;
    assign escaped      = out_reg.escaped;
    assign exit_energy  = out_reg.exit_energy;
    assign energy_bin   = out_reg.energy_bin;
    assign angle_bin    = out_reg.angle_bin;
    assign bin_count    = out_reg.bin_count;
    assign escape_total = out_reg.escape_total;
    assign sample_total = out_reg.sample_total;

`ifndef SYNTHESIS
    // no command leaves the queue during the power-up clearing pass
    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.init_clear |-> !q_pop)
        else $error("command taken during clearing pass");

    // the sequencer takes a command only when it has finished the last one
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> back_stat.idle)
        else $error("command taken while sequencer busy");

    // a handed-over result shows up on the result port
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (back_valid && back_ready) |=> !empty)
        else $error("result lost at output register");
`endif

endmodule

// ===== sim/ion_exit_energy_histogram_test.sv =====
// self-checking testbench of the ion exit energy histogram engine
module ion_exit_energy_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    // idling modes for the two sides
    localparam int MODE_FREE      = 0;
    localparam int MODE_SEND_IDLE = 1;
    localparam int MODE_POP_STALL = 2;
    localparam int MODE_BOTH      = 3;
    localparam int NUM_PHASES     = 7;
    // no-progress limit: initial sweep or a clear, plus margin
    localparam int STALL_LIMIT    = 300000;
    localparam int LAST_BIN       = 255;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         command = ieh_pkg::CMD_SAMPLE;
    logic [15:0]        depth_draw = '0;
    logic signed [15:0] dir_x = '0;
    logic signed [15:0] dir_y = '0;
    logic [15:0]        dir_z = '0;
    logic [7:0]         read_energy_index = '0;
    logic [7:0]         read_angle_index = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               escaped;
    logic [31:0]        exit_energy;
    logic [7:0]         energy_bin;
    logic [7:0]         angle_bin;
    logic [31:0]        bin_count;
    logic [31:0]        escape_total;
    logic [31:0]        sample_total;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    ion_exit_energy_histogram uut (.*);

    // 10 ns clock
    always #5 clk = ~clk;

    // one command as the sender sees it
    typedef struct {
        logic [1:0]    cmd;
        logic [15:0]   depth;
        logic [15:0]   x;
        logic [15:0]   y;
        logic [15:0]   z;
        logic [7:0]    rei;
        logic [7:0]    rai;
        bit            typed;    // expected result written in the table
        ieh_pkg::res_t want;
    } cmd_row_t;

    // mirror of the engine state and its registers
    longint unsigned hist_cells[int];
    longint unsigned esc_cnt, smp_cnt;
    longint unsigned r_thick, r_range, r_energy, r_nexp, r_ebw, r_abw;
    longint unsigned count_max = 64'hFFFF_FFFF;

    ieh_pkg::res_t pending_results[$];
    int   hit_cells[$];      // cells known to hold counts, for targeted reads

    int mismatches = 0;
    int watchdog = 0;
    int idle_mode = MODE_FREE;
    bit pop_hold = 1'b0;     // long receiver hold-off, timed by its own process
    int hold_cycles = 0;
    int n_samples = 0, n_escapes = 0, n_reads = 0, n_clears = 0, n_other = 0;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // f^n with f in Q0.32 and n in Q4.12
    function automatic longint unsigned frac_power(longint unsigned f, longint unsigned n);
        longint unsigned acc, r, s;
        acc = 64'd1 << 32;
        r = f;
        s = f;
        for (int j = 1; j <= 12; j++)
        begin
            r = root64(r << 32);
            if (n[12 - j])
                acc = (acc * r) >> 32;
        end
        for (int j = 12; j <= 15; j++)
        begin
            if (n[j])
                acc = (acc * s) >> 32;
            s = (s * s) >> 32;
        end
        return acc;
    endfunction

    function automatic longint unsigned bump(longint unsigned v);
        return (v < count_max) ? v + 1 : count_max;
    endfunction

    // advances the mirror by one command and gives the result it causes
    function automatic ieh_pkg::res_t histogram_step(cmd_row_t it);
        ieh_pkg::res_t o;
        longint signed sx, sy;
        longint unsigned c, s2, d, den, rem, f, en, eb, ab;
        int idx;
        o = '0;
        if (it.cmd == ieh_pkg::CMD_SAMPLE)
        begin
            smp_cnt = bump(smp_cnt);
            sx = 2 * longint'($signed(it.x));
            sy = 2 * longint'($signed(it.y));
            c = 0;
            if (it.z != 0)
            begin
                s2 = sx * sx + sy * sy + longint'(it.z) * longint'(it.z);
                c = (longint'(it.z) << 16) / root64(s2);
            end
            if (c != 0)
            begin
                d = r_thick * (65536 - longint'(it.depth));
                den = r_range * c;
                if (d < den)
                begin
                    rem = den - d;
                    f = 0;
                    for (int i = 0; i < 32; i++)
                    begin
                        rem <<= 1;
                        f <<= 1;
                        if (rem >= den)
                        begin
                            rem -= den;
                            f |= 1;
                        end
                    end
                    en = (r_energy * frac_power(f, r_nexp)) >> 32;
                    eb = (r_ebw != 0) ? en / r_ebw : LAST_BIN;
                    if (eb > LAST_BIN) eb = LAST_BIN;
                    ab = (r_abw != 0) ? c / r_abw : LAST_BIN;
                    if (ab > LAST_BIN) ab = LAST_BIN;
                    idx = int'(eb * 256 + ab);
                    hist_cells[idx] = bump(hist_cells.exists(idx) ? hist_cells[idx] : 0);
                    esc_cnt = bump(esc_cnt);
                    hit_cells.push_back(idx);
                    if (hit_cells.size() > 64) void'(hit_cells.pop_front());
                    o.escaped = 1'b1;
                    o.exit_energy = en[31:0];
                    o.energy_bin = eb[7:0];
                    o.angle_bin = ab[7:0];
                    o.bin_count = hist_cells[idx][31:0];
                    n_escapes++;
                end
            end
            n_samples++;
        end
        else if (it.cmd == ieh_pkg::CMD_READ)
        begin
            idx = int'(it.rei) * 256 + int'(it.rai);
            o.energy_bin = it.rei;
            o.angle_bin = it.rai;
            o.bin_count = hist_cells.exists(idx) ? hist_cells[idx][31:0] : 32'd0;
            n_reads++;
        end
        else if (it.cmd == ieh_pkg::CMD_CLEAR)
        begin
            hist_cells.delete();
            hit_cells.delete();
            esc_cnt = 0;
            smp_cnt = 0;
            n_clears++;
        end
        else
            n_other++;
        o.escape_total = (esc_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : esc_cnt[31:0];
        o.sample_total = (smp_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : smp_cnt[31:0];
        return o;
    endfunction

    // one command transaction; push stays high across back-to-back commands
    task automatic send_cmd(cmd_row_t it);
        ieh_pkg::res_t predicted;
        while ((idle_mode == MODE_SEND_IDLE || idle_mode == MODE_BOTH)
               && $urandom_range(99) < 76)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        command = it.cmd;
        depth_draw = it.depth;
        dir_x = it.x;
        dir_y = it.y;
        dir_z = it.z;
        read_energy_index = it.rei;
        read_angle_index = it.rai;
        do
            @(posedge clk);
        while (full);
        predicted = histogram_step(it);
        pending_results.push_back(it.typed ? it.want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint unsigned val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[31:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ieh_pkg::REG_THICKNESS: r_thick  = val & 64'hFF_FFFF;
            ieh_pkg::REG_ION_RANGE: r_range  = val & 64'hFF_FFFF;
            ieh_pkg::REG_INIT_EN:   r_energy = val & 64'hFFFF_FFFF;
            ieh_pkg::REG_LOSS_EXP:  r_nexp   = val & 64'hFFFF;
            ieh_pkg::REG_EBIN_W:    r_ebw    = val & 64'hFFFF_FFFF;
            ieh_pkg::REG_ABIN_W:    r_abw    = val & 64'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // sender pause: nothing is written until every result is back
    task automatic drain();
        push = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_regs(longint unsigned t, longint unsigned rg, longint unsigned e,
                            longint unsigned n, longint unsigned ew, longint unsigned aw);
        write_reg(ieh_pkg::REG_THICKNESS, t);
        write_reg(ieh_pkg::REG_ION_RANGE, rg);
        write_reg(ieh_pkg::REG_INIT_EN, e);
        write_reg(ieh_pkg::REG_LOSS_EXP, n);
        write_reg(ieh_pkg::REG_EBIN_W, ew);
        write_reg(ieh_pkg::REG_ABIN_W, aw);
    endtask

    function automatic cmd_row_t row(logic [1:0] cmd, logic [15:0] u, logic [15:0] x,
                                     logic [15:0] y, logic [15:0] z,
                                     logic [7:0] rei, logic [7:0] rai);
        cmd_row_t r;
        r.cmd = cmd; r.depth = u; r.x = x; r.y = y; r.z = z;
        r.rei = rei; r.rai = rai; r.typed = 1'b0; r.want = '0;
        return r;
    endfunction

    function automatic cmd_row_t typed_row(cmd_row_t r, ieh_pkg::res_t w);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    // random command: mostly samples with random draws, reads aimed at hit cells half the time
    function automatic cmd_row_t random_cmd(bit reads_only);
        cmd_row_t r;
        int pick, hit;
        r = row(ieh_pkg::CMD_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (reads_only || (pick >= 70 && pick < 96))
        begin
            r.cmd = ieh_pkg::CMD_READ;
            if (hit_cells.size() != 0 && $urandom_range(1) == 1)
            begin
                hit = hit_cells[$urandom_range(hit_cells.size() - 1)];
                r.rei = 8'(hit >> 8);
                r.rai = 8'(hit);
            end
        end
        else if (pick >= 96)
            r.cmd = ieh_pkg::CMD_NONE;
        else if (pick < 5)
            r.z = (pick < 2) ? 16'd0 : 16'($urandom_range(3));
        return r;
    endfunction

    // result side: stalls per mode, or a long hold-off
    always @(negedge clk)
    begin
        if (pop_hold)
            pop <= 1'b0;
        else if (idle_mode == MODE_POP_STALL || idle_mode == MODE_BOTH)
            pop <= ($urandom_range(99) >= 76);
        else
            pop <= 1'b1;
    end

    // long hold-off timer
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                pop_hold <= 1'b0;
        end
    end

    // result checker: every popped transaction against the oldest expectation
    always @(posedge clk)
    begin
        ieh_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (escaped !== want.escaped || exit_energy !== want.exit_energy
                    || energy_bin !== want.energy_bin || angle_bin !== want.angle_bin
                    || bin_count !== want.bin_count || escape_total !== want.escape_total
                    || sample_total !== want.sample_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: exp esc=%0d e=%0d eb=%0d ab=%0d",
                                 $realtime, want.escaped, want.exit_energy,
                                 want.energy_bin, want.angle_bin);
                        $display("  exp cnt=%0d tot=%0d/%0d",
                                 want.bin_count, want.escape_total, want.sample_total);
                        $display("  got esc=%0d e=%0d eb=%0d ab=%0d cnt=%0d tot=%0d/%0d",
                                 escaped, exit_energy, energy_bin, angle_bin,
                                 bin_count, escape_total, sample_total);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t directed[$];
        ieh_pkg::res_t z0, w;
        int phase_items[NUM_PHASES];

        phase_items = '{40, 380, 380, 380, 380, 60, 380};
        hist_cells.delete();
        esc_cnt = 0;
        smp_cnt = 0;
        r_thick = ieh_pkg::THICKNESS_RST;
        r_range = ieh_pkg::ION_RANGE_RST;
        r_energy = ieh_pkg::INIT_EN_RST;
        r_nexp = ieh_pkg::LOSS_EXP_RST;
        r_ebw = ieh_pkg::EBIN_W_RST;
        r_abw = ieh_pkg::ABIN_W_RST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part; typed rows are the obvious ones
        z0 = '0;
        directed.push_back(typed_row(row(ieh_pkg::CMD_READ, 0, 0, 0, 0, 0, 0), z0));
        directed.push_back(typed_row(row(ieh_pkg::CMD_READ, 0, 0, 0, 0, 8'hFF, 8'hFF), '{
            escaped: 0, exit_energy: 0, energy_bin: 8'hFF, angle_bin: 8'hFF,
            bin_count: 0, escape_total: 0, sample_total: 0}));
        directed.push_back(typed_row(row(ieh_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 8'hFF, 8'hFF), z0));
        // zero direction never escapes but still counts as a sample
        w = z0;
        w.sample_total = 1;
        directed.push_back(typed_row(row(ieh_pkg::CMD_SAMPLE, 16'h8000, 0, 0, 0, 0, 0), w));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0001,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'hF000, 16'h0001, 16'hFFFF, 16'h8000,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_SAMPLE, 16'hC000, 16'h4000, 16'hC000, 16'h4000,
                               0, 0));
        directed.push_back(row(ieh_pkg::CMD_READ, 0, 0, 0, 0, 8'd0, 8'd255));
        directed.push_back(row(ieh_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0));
        directed.push_back(typed_row(row(ieh_pkg::CMD_CLEAR, 16'hFFFF, 16'h7FFF, 16'h8000,
                                         16'hFFFF, 8'hAA, 8'h55), z0));
        directed.push_back(typed_row(row(ieh_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'd199), '{
            escaped: 0, exit_energy: 0, energy_bin: 0, angle_bin: 8'd199,
            bin_count: 0, escape_total: 0, sample_total: 0}));
        foreach (directed[i])
            send_cmd(directed[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_mode = p % 4;
            case (p)
                0: set_regs(3000, 10400, 68000, 5939, 500, 328);
                // largest values, finest bins
                1: set_regs(24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
                // smallest legal values
                2: set_regs(1, 1, 1, 1, 1, 1);
                // zero exponent and zero bin widths send everything to the last bins
                3: set_regs(0, 9000, 123456, 0, 0, 0);
                4: set_regs($urandom_range(100, 20000), $urandom_range(5000, 60000),
                            $urandom_range(1000, 32'h00FF_FFFF), $urandom_range(16'hFFFF),
                            $urandom_range(1, 100000), $urandom_range(1, 2000));
                // zero range: nothing escapes
                5: set_regs(3000, 0, 68000, 5939, 500, 328);
                6: set_regs(2000, 12000, 32'h8000_0000, 16'h1000, 32'h0080_0000, 256);
                default: ;
            endcase
            if (p == 4)
                send_cmd(row(ieh_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
            if (p == 0)
            begin
                // hold the result side while reads keep arriving, so full stalls input
                pop_hold = 1'b1;
                hold_cycles = 400;
                for (int k = 0; k < 12; k++)
                    send_cmd(random_cmd(1'b1));
            end
            for (int k = 0; k < phase_items[p]; k++)
                send_cmd(random_cmd(1'b0));
            drain();
        end

        idle_mode = MODE_FREE;
        repeat (50) @(posedge clk);
        $display("covered %0d samples (%0d escaped), %0d reads, %0d clears, %0d unused codes",
                 n_samples, n_escapes, n_reads, n_clears, n_other);
        $display("over %0d register settings with all idling modes; %0d mismatches",
                 NUM_PHASES, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ieh_pkg.sv
rtl/core/ieh_front.sv
rtl/core/ieh_fifo.sv
rtl/core/ieh_isqrt.sv
rtl/core/ieh_div.sv
rtl/core/ieh_back.sv
rtl/core/ion_exit_energy_histogram.sv
sim/ion_exit_energy_histogram_test.sv
